@@ sv/bfp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfp_pkg
// Shared types and codes for the bit FIFO packer: request and response
// payloads, item kinds and the engine status bundle.
// ----------------------------------------------------------------------------
package bfp_pkg;

   localparam int DEPTH_WORDS_DEFAULT = 64;
   localparam int WORD_BITS           = 32;

   localparam logic [1:0] KIND_PUSH = 2'd0;
   localparam logic [1:0] KIND_TRIM = 2'd1;
   localparam logic [1:0] KIND_POP  = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] value;
      logic [6:0]  count;
   } req_type;

   typedef struct packed {
      logic [63:0] read_data;
      logic [11:0] bits_held;
      logic [6:0]  words_held;
      logic        is_empty;
      logic        overflow;
      logic        underflow;
   } rsp_type;

   typedef struct packed {
      logic        done;
      logic [63:0] read_data;
      logic        overflow;
      logic        underflow;
      logic [4:0]  rd_offset;
   } stat_type;

endpackage
`default_nettype wire

@@ sv/bfp_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfp_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module bfp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ sv/bfp_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfp_engine
// Sequencer and datapath: holds the ring pointers and fill level, performs
// read-modify-write of the word store for pushes and a three-word gather
// for pops.
// ----------------------------------------------------------------------------
module bfp_engine
   import bfp_pkg::*;
#(
   parameter int DEPTH_WORDS = DEPTH_WORDS_DEFAULT,
   localparam int AW  = $clog2(DEPTH_WORDS),
   localparam int CAP = DEPTH_WORDS * WORD_BITS,
   localparam int FW  = $clog2(CAP + 1)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire req_type       req,
   output logic               busy,
   output logic               wr_en,
   output logic [AW-1:0]      wr_addr,
   output logic [31:0]        wr_data,
   output logic [AW-1:0]      rd_addr,
   input  wire logic [31:0]   rd_data,
   output stat_type           status,
   output logic [FW-1:0]      fill
);

   localparam int PW = AW + 5;
   localparam logic [PW:0]   CAP_P = (PW + 1)'(CAP);
   localparam logic [FW-1:0] CAP_F = FW'(CAP);
   localparam logic [AW:0]   DEPTH_P = (AW + 1)'(DEPTH_WORDS);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_PLAN    = 4'd1;
   localparam logic [3:0] S_ALIGN   = 4'd2;
   localparam logic [3:0] S_MERGE0  = 4'd3;
   localparam logic [3:0] S_MERGE1  = 4'd4;
   localparam logic [3:0] S_POP1    = 4'd5;
   localparam logic [3:0] S_POP2    = 4'd6;
   localparam logic [3:0] S_POP3    = 4'd7;
   localparam logic [3:0] S_EXTRACT = 4'd8;
   localparam logic [3:0] S_DONE    = 4'd9;

   logic [3:0]    state_ff,  state_in;
   logic [1:0]    kind_ff,   kind_in;
   logic [31:0]   value_ff,  value_in;
   logic [6:0]    count_ff,  count_in;
   logic [5:0]    n_ff,      n_in;
   logic [PW-1:0] wp_ff,     wp_in;
   logic [PW-1:0] rp_ff,     rp_in;
   logic [FW-1:0] fill_ff,   fill_in;
   logic [AW-1:0] w0_ff,     w0_in;
   logic [AW-1:0] w1_ff,     w1_in;
   logic [4:0]    off_ff,    off_in;
   logic [6:0]    cnt_ff,    cnt_in;
   logic          span_ff,   span_in;
   logic [63:0]   data_ff,   data_in;
   logic [63:0]   mask_ff,   mask_in;
   logic [95:0]   win_ff,    win_in;
   logic [63:0]   result_ff, result_in;
   logic          ovf_ff,    ovf_in;
   logic          udf_ff,    udf_in;

   logic          accept;
   logic [6:0]    pop_cnt;
   logic [FW-1:0] free_bits;
   logic [31:0]   val_top;
   logic [31:0]   mask_top;
   logic [95:0]   win_shift;
   logic [63:0]   win_top;
   logic [PW:0]   tail_sum;
   logic [PW:0]   tail_pos;

   function automatic logic [5:0] bit_len(input logic [31:0] v);
      logic [5:0] n;
      n = 6'd0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) begin
            n = 6'(i + 1);
         end
      end
      return n;
   endfunction

   function automatic logic [AW-1:0] next_word(input logic [AW-1:0] w);
      logic [AW:0] s;
      s = {1'b0, w} + (AW + 1)'(1);
      if (s == DEPTH_P) begin
         s = '0;
      end
      return s[AW-1:0];
   endfunction

   function automatic logic [PW-1:0] advance(input logic [PW-1:0] pos,
                                             input logic [6:0]    step);
      logic [PW:0] s;
      s = {1'b0, pos} + (PW + 1)'(step);
      if (s >= CAP_P) begin
         s = s - CAP_P;
      end
      return s[PW-1:0];
   endfunction

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE) && (state_ff != S_DONE);
   assign pop_cnt   = (count_ff > 7'd64) ? 7'd64 : count_ff;
   assign free_bits = CAP_F - fill_ff;
   assign val_top   = value_ff << (6'd32 - n_ff);
   assign mask_top  = 32'hFFFF_FFFF << (6'd32 - n_ff);
   assign win_shift = win_ff << off_ff;
   assign win_top   = win_shift[95:32];

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      value_in  = value_ff;
      count_in  = count_ff;
      n_in      = n_ff;
      wp_in     = wp_ff;
      rp_in     = rp_ff;
      fill_in   = fill_ff;
      w0_in     = w0_ff;
      w1_in     = w1_ff;
      off_in    = off_ff;
      cnt_in    = cnt_ff;
      span_in   = span_ff;
      data_in   = data_ff;
      mask_in   = mask_ff;
      win_in    = win_ff;
      result_in = result_ff;
      ovf_in    = ovf_ff;
      udf_in    = udf_ff;
      wr_en     = 1'b0;
      wr_addr   = w0_ff;
      wr_data   = '0;
      rd_addr   = '0;

      case (state_ff)
         S_IDLE, S_DONE: begin
            state_in = S_IDLE;
            if (accept || (start && state_ff == S_DONE)) begin
               kind_in  = req.kind;
               value_in = req.value;
               count_in = req.count;
               state_in = S_PLAN;
            end
         end
         S_PLAN: begin
            result_in = '0;
            ovf_in    = 1'b0;
            udf_in    = 1'b0;
            n_in      = (kind_ff == KIND_TRIM) ? bit_len(value_ff) :
                        ((count_ff > 7'd32) ? 6'd32 : count_ff[5:0]);
            cnt_in    = pop_cnt;
            w0_in     = rp_ff[PW-1:5];
            w1_in     = next_word(rp_ff[PW-1:5]);
            off_in    = rp_ff[4:0];
            rd_addr   = rp_ff[PW-1:5];
            case (kind_ff)
               KIND_PUSH, KIND_TRIM: begin
                  state_in = S_ALIGN;
               end
               KIND_POP: begin
                  if (FW'(pop_cnt) > fill_ff) begin
                     udf_in   = 1'b1;
                     state_in = S_DONE;
                  end else if (pop_cnt == 7'd0) begin
                     state_in = S_DONE;
                  end else begin
                     rp_in    = advance(rp_ff, pop_cnt);
                     fill_in  = fill_ff - FW'(pop_cnt);
                     state_in = S_POP1;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_ALIGN: begin
            data_in = {val_top, 32'h0} >> wp_ff[4:0];
            mask_in = {mask_top, 32'h0} >> wp_ff[4:0];
            span_in = ({1'b0, wp_ff[4:0]} + n_ff) > 6'd32;
            w0_in   = wp_ff[PW-1:5];
            w1_in   = next_word(wp_ff[PW-1:5]);
            rd_addr = wp_ff[PW-1:5];
            if (FW'(n_ff) > free_bits) begin
               ovf_in   = 1'b1;
               state_in = S_DONE;
            end else if (n_ff == 6'd0) begin
               state_in = S_DONE;
            end else begin
               wp_in    = advance(wp_ff, {1'b0, n_ff});
               fill_in  = fill_ff + FW'(n_ff);
               state_in = S_MERGE0;
            end
         end
         S_MERGE0: begin
            wr_en   = 1'b1;
            wr_addr = w0_ff;
            wr_data = (rd_data & ~mask_ff[63:32]) | data_ff[63:32];
            rd_addr = w1_ff;
            state_in = span_ff ? S_MERGE1 : S_DONE;
         end
         S_MERGE1: begin
            wr_en    = 1'b1;
            wr_addr  = w1_ff;
            wr_data  = (rd_data & ~mask_ff[31:0]) | data_ff[31:0];
            state_in = S_DONE;
         end
         S_POP1: begin
            win_in   = {win_ff[63:0], rd_data};
            rd_addr  = w1_ff;
            state_in = S_POP2;
         end
         S_POP2: begin
            win_in   = {win_ff[63:0], rd_data};
            rd_addr  = next_word(w1_ff);
            state_in = S_POP3;
         end
         S_POP3: begin
            win_in   = {win_ff[63:0], rd_data};
            state_in = S_EXTRACT;
         end
         S_EXTRACT: begin
            result_in = win_top >> (7'd64 - cnt_ff);
            state_in  = S_DONE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wp_ff    <= '0;
         rp_ff    <= '0;
         fill_ff  <= '0;
         ovf_ff   <= 1'b0;
         udf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         fill_ff  <= fill_in;
         ovf_ff   <= ovf_in;
         udf_ff   <= udf_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      value_ff  <= value_in;
      count_ff  <= count_in;
      n_ff      <= n_in;
      w0_ff     <= w0_in;
      w1_ff     <= w1_in;
      off_ff    <= off_in;
      cnt_ff    <= cnt_in;
      span_ff   <= span_in;
      data_ff   <= data_in;
      mask_ff   <= mask_in;
      win_ff    <= win_in;
      result_ff <= result_in;
   end

   always_comb begin
      status.done      = (state_ff == S_DONE);
      status.read_data = result_ff;
      status.overflow  = ovf_ff;
      status.underflow = udf_ff;
      status.rd_offset = rp_ff[4:0];
   end

   assign fill = fill_ff;

   // ring consistency: head plus fill lands on the tail
   assign tail_sum = {1'b0, rp_ff} + (PW + 1)'(fill_ff);
   assign tail_pos = (tail_sum >= CAP_P) ? (tail_sum - CAP_P) : tail_sum;

   a_ring_consistent: assert property (@(posedge clock) disable iff (reset)
      tail_pos == {1'b0, wp_ff})
      else $error("ring pointers and fill level disagree");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CAP_F)
      else $error("fill level above capacity");

   a_write_in_merge: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_MERGE0 || state_ff == S_MERGE1))
      else $error("store written outside a merge step");

   a_ovf_push_only: assert property (@(posedge clock) disable iff (reset)
      (status.done && ovf_ff) |-> (kind_ff == KIND_PUSH || kind_ff == KIND_TRIM))
      else $error("overflow on a non-push item");

   a_udf_pop_only: assert property (@(posedge clock) disable iff (reset)
      (status.done && udf_ff) |-> (kind_ff == KIND_POP && $stable(fill_ff)))
      else $error("underflow on a non-pop item or with fill moving");

endmodule
`default_nettype wire

@@ sv/bit_fifo_packer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bit_fifo_packer
// Bit-granular FIFO in 32-bit words, filled most significant bit first.
//
// Request: drive req_data and raise start; the transfer happens on a rising
// edge with start high and busy low. kind selects push of the low count bits
// (up to 32), trimmed push from the highest set bit, or pop of up to 64 bits.
// Response: one per request, on rsp_data for a single cycle with rsp_strobe
// high. The receiver cannot stall; a response is never held back.
// Sequence from transfer to strobe: a push plans, aligns, then makes one
// read-modify-write of the word store per word touched; a pop plans, makes
// three reads of the word store, then extracts; rejected or empty items
// finish after planning or aligning. The strobe is registered after done.
// A new request is taken in the cycle that closes the previous one, and no
// new request is taken while the block is busy.
// Reset clears the pointers and fill level; the word store is not cleared,
// as only written bits are ever read.
// ----------------------------------------------------------------------------
module bit_fifo_packer
   import bfp_pkg::*;
#(
   parameter int DEPTH_WORDS = DEPTH_WORDS_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   localparam int AW  = $clog2(DEPTH_WORDS);
   localparam int CAP = DEPTH_WORDS * WORD_BITS;
   localparam int FW  = $clog2(CAP + 1);

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_data;
   logic [AW-1:0] rd_addr;
   logic [31:0]   rd_data;
   stat_type      status;
   logic [FW-1:0] fill;

   logic [FW:0]   span_sum;
   logic [FW:0]   words_raw;
   logic [FW:0]   words_clamped;

   rsp_type       rsp_ff, rsp_in;
   logic          strobe_ff;

   bfp_engine #(
      .DEPTH_WORDS(DEPTH_WORDS)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req     (req_data),
      .busy    (busy),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .status  (status),
      .fill    (fill)
   );

   bfp_ram #(
      .WIDTH(WORD_BITS),
      .DEPTH(DEPTH_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // words occupied, counting a partial word at either end
   assign span_sum  = (FW + 1)'(status.rd_offset) + (FW + 1)'(fill) + (FW + 1)'(31);
   assign words_raw = (fill == '0) ? '0 : (span_sum >> 5);
   assign words_clamped = (words_raw > (FW + 1)'(DEPTH_WORDS)) ?
                          (FW + 1)'(DEPTH_WORDS) : words_raw;

   always_comb begin
      rsp_in.read_data  = status.read_data;
      rsp_in.bits_held  = 12'(fill);
      rsp_in.words_held = 7'(words_clamped);
      rsp_in.is_empty   = (fill == '0);
      rsp_in.overflow   = status.overflow;
      rsp_in.underflow  = status.underflow;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= status.done;
      end
   end

   always_ff @(posedge clock) begin
      if (status.done) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
`default_nettype wire

@@ bench/tb_bit_fifo_packer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bit_fifo_packer
// Self-checking bench for the bit FIFO packer. A queue of pushes, trimmed
// pushes, pops and items of the unused kind is built up front: a short
// directed list, then random fill, drain and mixed phases that run the ring
// full, wrap it and empty it. A clocked driver feeds the queue with random
// gaps. At each transfer a shadow bit ring works out the response. A monitor
// checks every strobed response against the oldest one awaited.
// ----------------------------------------------------------------------------
module tb_bit_fifo_packer;
   import bfp_pkg::*;

   localparam int unsigned CAP_BITS = DEPTH_WORDS_DEFAULT * WORD_BITS;
   localparam logic [1:0]  KIND_NONE = 2'd3;
   localparam int          N_RANDOM = 400;
   localparam int          QUIET_LO = 150;
   localparam int          QUIET_HI = 260;
   localparam int          LIMIT_CYCLES = 200000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   bit_fifo_packer i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the bit ring
   logic        shadow_bits [0:CAP_BITS-1];
   int unsigned wr_pos = 0;
   int unsigned rd_pos = 0;
   int unsigned fill_bits = 0;

   req_type     queued_reqs [$];
   rsp_type     awaited_rsps [$];
   int unsigned plan_fill = 0;
   int          n_items = 0;
   int          n_accepted = 0;
   int          n_errors = 0;
   int          gap_left = 0;
   int          cycles = 0;
   rsp_type     due;

   function automatic int unsigned bit_len(logic [31:0] v);
      int unsigned n;
      n = 0;
      for (int i = 31; i >= 0; i--) begin
         if (v[i] && n == 0) n = i + 1;
      end
      return n;
   endfunction

   function automatic int unsigned push_len(req_type r);
      if (r.kind == KIND_PUSH) return (r.count > 32) ? 32 : r.count;
      return bit_len(r.value);
   endfunction

   function automatic int unsigned pop_len(req_type r);
      return (r.count > 64) ? 64 : r.count;
   endfunction

   // applies one request to the shadow ring and returns the response
   function automatic rsp_type shadow_apply(req_type r);
      rsp_type     o;
      int unsigned n;
      int unsigned span;
      o = '0;
      case (r.kind)
         KIND_PUSH, KIND_TRIM: begin
            n = push_len(r);
            if (n > CAP_BITS - fill_bits) begin
               o.overflow = 1'b1;
            end else begin
               for (int i = n; i > 0; i--) begin
                  shadow_bits[wr_pos] = r.value[i-1];
                  wr_pos = (wr_pos + 1) % CAP_BITS;
               end
               fill_bits += n;
            end
         end
         KIND_POP: begin
            n = pop_len(r);
            if (n > fill_bits) begin
               o.underflow = 1'b1;
            end else begin
               for (int i = 0; i < n; i++) begin
                  o.read_data = {o.read_data[62:0], shadow_bits[rd_pos]};
                  rd_pos = (rd_pos + 1) % CAP_BITS;
               end
               fill_bits -= n;
            end
         end
         default: ;
      endcase
      span = (fill_bits == 0) ? 0 : ((rd_pos % 32) + fill_bits + 31) / 32;
      if (span > DEPTH_WORDS_DEFAULT) span = DEPTH_WORDS_DEFAULT;
      o.bits_held  = 12'(fill_bits);
      o.words_held = 7'(span);
      o.is_empty   = (fill_bits == 0);
      return o;
   endfunction

   // queues one request and tracks the fill it will leave, to steer the plan
   task automatic add_req(logic [1:0] k, logic [31:0] v, logic [6:0] c);
      req_type     r;
      int unsigned n;
      r = '{kind: k, value: v, count: c};
      queued_reqs.push_back(r);
      n_items++;
      if (k == KIND_PUSH || k == KIND_TRIM) begin
         n = push_len(r);
         if (n <= CAP_BITS - plan_fill) plan_fill += n;
      end else if (k == KIND_POP) begin
         n = pop_len(r);
         if (n <= plan_fill) plan_fill -= n;
      end
   endtask

   // driver; a gap counts only cycles in which the block could take a transfer
   always @(posedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         gap_left = 0;
      end else begin
         if (start && !busy) begin
            awaited_rsps.push_back(shadow_apply(req_data));
            n_accepted++;
            if ((n_accepted < QUIET_LO || n_accepted >= QUIET_HI) &&
                $urandom_range(99) < 55)
               gap_left = $urandom_range(1, 7);
         end
         if (!start || !busy) begin
            if (!start && !busy && gap_left > 0) begin
               gap_left--;
            end
            if (gap_left > 0) begin
               start <= 1'b0;
            end else if (queued_reqs.size() > 0) begin
               req_data <= queued_reqs.pop_front();
               start    <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (awaited_rsps.size() == 0) begin
            $display("%0t: response with none awaited: got %p", $time, rsp_data);
            n_errors++;
         end else begin
            due = awaited_rsps.pop_front();
            if (rsp_data !== due) begin
               $display("%0t: mismatch: expected data=%h bits=%0d words=%0d e/o/u=%b%b%b",
                        $time, due.read_data, due.bits_held, due.words_held,
                        due.is_empty, due.overflow, due.underflow);
               $display("%0t:           actual data=%h bits=%0d words=%0d e/o/u=%b%b%b",
                        $time, rsp_data.read_data, rsp_data.bits_held,
                        rsp_data.words_held, rsp_data.is_empty,
                        rsp_data.overflow, rsp_data.underflow);
               n_errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT_CYCLES) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int          seg;
      int          seg_len;
      int          n_rand;
      int          roll;
      int unsigned room;
      logic [1:0]  k;
      logic [31:0] v;
      logic [6:0]  c;

      // directed
      add_req(KIND_POP,  32'h0, 7'd0);
      add_req(KIND_POP,  32'h0, 7'd1);
      add_req(KIND_PUSH, 32'hFFFF_FFFF, 7'd0);
      add_req(KIND_TRIM, 32'h0, 7'd5);
      add_req(KIND_PUSH, 32'hFFFF_FFFF, 7'd32);
      add_req(KIND_PUSH, 32'hFFFF_FFFE, 7'd1);
      add_req(KIND_PUSH, 32'hA5A5_A5A5, 7'd127);
      add_req(KIND_TRIM, 32'h8000_0000, 7'd0);
      add_req(KIND_TRIM, 32'h0000_0001, 7'd64);
      add_req(KIND_PUSH, 32'h0000_005A, 7'd7);
      add_req(KIND_NONE, 32'h1234_5678, 7'd64);
      add_req(KIND_POP,  32'hFFFF_FFFF, 7'd64);
      add_req(KIND_POP,  32'h0, 7'd127);
      add_req(KIND_POP,  32'h0, 7'(plan_fill));
      add_req(KIND_PUSH, 32'h0, 7'd32);
      add_req(KIND_PUSH, 32'h7FFF_FFFF, 7'd31);
      add_req(KIND_POP,  32'h0, 7'd64);
      add_req(KIND_NONE, 32'h0, 7'd0);
      add_req(KIND_POP,  32'h0, 7'd63);
      add_req(KIND_POP,  32'h0, 7'd0);

      // random phases: fill, drain, mixed
      n_rand = 0;
      seg = 0;
      while (n_rand < N_RANDOM) begin
         seg_len = (seg % 3 == 0) ? $urandom_range(90, 140) : $urandom_range(40, 80);
         for (int i = 0; i < seg_len && n_rand < N_RANDOM; i++) begin
            roll = $urandom_range(99);
            room = CAP_BITS - plan_fill;
            v = $urandom();
            c = 7'($urandom_range(0, 64));
            k = KIND_POP;
            case (seg % 3)
               0: begin
                  if (room > 0 && room <= 32 && roll < 30) begin
                     k = KIND_PUSH;
                     c = 7'(room);
                  end else if (roll < 60) begin
                     k = KIND_PUSH;
                     c = 7'($urandom_range(20, 32));
                  end else if (roll < 88) begin
                     k = KIND_TRIM;
                     v = v >> $urandom_range(0, 8);
                  end else if (roll < 92) begin
                     k = KIND_PUSH;
                     c = 7'($urandom_range(0, 127));
                  end
               end
               1: begin
                  if (roll < 15) begin
                     c = (plan_fill > 64) ? 7'd64 : 7'(plan_fill);
                  end else if (roll < 25) begin
                     c = 7'($urandom_range(65, 127));
                  end else if (roll >= 90) begin
                     k = KIND_TRIM;
                     v = v >> $urandom_range(0, 31);
                  end else if (roll >= 80) begin
                     k = KIND_PUSH;
                     c = 7'($urandom_range(1, 32));
                  end
               end
               default: begin
                  if (roll < 30) begin
                     k = KIND_PUSH;
                     c = 7'($urandom_range(0, 127));
                  end else if (roll < 55) begin
                     k = KIND_TRIM;
                     v = (roll < 33) ? 32'h0 : v >> $urandom_range(0, 31);
                  end else if (roll >= 95) begin
                     k = KIND_NONE;
                     c = 7'($urandom_range(0, 127));
                  end
               end
            endcase
            add_req(k, v, c);
            if (k != KIND_NONE) n_rand++;
         end
         seg++;
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (n_accepted < n_items) @(posedge clock);
      while (awaited_rsps.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (n_errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
